/* rtl/u8st_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_pkg
// Shared types and constants of the UTF-8 sanitizer with output byte limit.
// ----------------------------------------------------------------------------
package u8st_pkg;

    // Most result bytes one input byte can cause
    localparam int MaxRes = 4;

    // Byte sent in place of a broken or rejected byte
    localparam logic [7:0] ReplByte = 8'h3F;

    // Byte limit after reset
    localparam logic [15:0] LimitReset = 16'd1024;

    typedef logic [7:0] t_byte;

    // One run of results caused by one accepted input byte
    typedef struct packed {
        t_byte [MaxRes-1:0] bytes;    // bytes in output order, entry 0 first
        logic  [2:0]        n_res;    // number of results in the run, 1..4
        logic               bare;     // single end marker without a byte
        logic               str_end;  // run closes the string
    } t_run;

endpackage

/* rtl/u8st_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_in_if
// Input channel: one raw string byte per transfer, flag on the last byte.
// ----------------------------------------------------------------------------
interface u8st_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

/* rtl/u8st_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_out_if
// Output channel: one sanitized byte or bare end marker per transfer.
// ----------------------------------------------------------------------------
interface u8st_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       string_end;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_present,
                    output string_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_present,
                    input string_end, input run_last, output ready);
endinterface

/* rtl/u8st_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_front
// Takes input bytes, tracks the pending multi-byte sequence and the output
// budget, and builds the run of result bytes for each accepted byte.
// ----------------------------------------------------------------------------
module u8st_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u8st_in_if.sink          i_in,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    input  logic             i_q_ready,
    output logic             o_push,
    output u8st_pkg::t_run   o_run
);

    localparam logic [20:0] MinCp2    = 21'h00080;
    localparam logic [20:0] MinCp3    = 21'h00800;
    localparam logic [20:0] MinCp4    = 21'h10000;
    localparam logic [20:0] SurrLo    = 21'h0D800;
    localparam logic [20:0] SurrHi    = 21'h0DFFF;
    localparam logic [20:0] MaxCp     = 21'h10FFFF;

    // Sequence width for a lead byte: 0 means the byte cannot start one
    function automatic logic [2:0] lead_width(input logic [7:0] lead);
        logic [2:0] w;
        unique case (lead) inside
            [8'h00:8'h7F]: w = 3'd1;
            [8'hC2:8'hDF]: w = 3'd2;
            [8'hE0:8'hEF]: w = 3'd3;
            [8'hF0:8'hF4]: w = 3'd4;
            default:       w = 3'd0;
        endcase
        return w;
    endfunction

    logic                r_stopped, n_stopped;
    logic [15:0]         r_byte_limit;
    logic [15:0]         r_emit_cnt, n_emit_cnt;
    logic [1:0]          r_pend_cnt, n_pend_cnt;
    logic [2:0]          r_exp_width, n_exp_width;
    u8st_pkg::t_byte     r_pend [3];

    logic                accept;
    logic [7:0]          b;
    logic                fin;
    logic [2:0]          w_lead;
    logic                active;
    logic                is_cont;
    logic                complete;
    logic                append;
    logic [20:0]         cp;
    logic                cp_ok;
    logic [2:0]          n_q;
    logic                has_ascii;
    logic                multi;
    logic                lead_wr;
    logic                app_wr;
    logic [2:0]          n_tot;
    logic                stop_hit;
    logic [2:0]          n_emit;
    u8st_pkg::t_byte     seq [u8st_pkg::MaxRes];
    u8st_pkg::t_byte [u8st_pkg::MaxRes-1:0] run_bytes;
    logic [1:0]          last_idx;

    assign accept       = i_in.valid && i_q_ready;
    assign i_in.ready   = i_q_ready;
    assign b            = i_in.in_byte;
    assign fin          = i_in.is_final;

    // Classify the byte against the pending sequence
    assign w_lead   = lead_width(b);
    assign active   = (r_pend_cnt != 2'd0) && (r_exp_width > {1'b0, r_pend_cnt});
    assign is_cont  = (b[7:6] == 2'b10);
    assign complete = active && is_cont && (({1'b0, r_pend_cnt} + 3'd1) == r_exp_width);
    assign append   = active && is_cont && !complete;

    // Code point of the finished sequence and its range checks
    always_comb begin
        case (r_exp_width)
            3'd2:    cp = {10'd0, r_pend[0][4:0], b[5:0]};
            3'd3:    cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], b[5:0]};
            default: cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
        endcase
    end

    assign cp_ok = ((r_exp_width == 3'd2 && cp >= MinCp2) ||
                    (r_exp_width == 3'd3 && cp >= MinCp3) ||
                    (r_exp_width == 3'd4 && cp >= MinCp4)) &&
                   !(cp >= SurrLo && cp <= SurrHi) && (cp <= MaxCp);

    // Shape of the run: n_q replacements, then an optional ASCII byte,
    // or one whole multi-byte character
    always_comb begin
        n_q         = 3'd0;
        has_ascii   = 1'b0;
        multi       = 1'b0;
        n_pend_cnt  = 2'd0;
        n_exp_width = 3'd0;
        lead_wr     = 1'b0;
        app_wr      = 1'b0;
        if (complete) begin
            if (cp_ok) begin
                multi = 1'b1;
            end else begin
                n_q = r_exp_width;
            end
        end else if (append) begin
            n_pend_cnt  = r_pend_cnt + 2'd1;
            n_exp_width = r_exp_width;
            app_wr      = 1'b1;
        end else begin
            // broken sequence: every pending byte becomes a replacement
            n_q = active ? {1'b0, r_pend_cnt} : 3'd0;
            if (w_lead == 3'd1) begin
                has_ascii = 1'b1;
            end else if (w_lead == 3'd0) begin
                n_q = n_q + 3'd1;
            end else begin
                n_pend_cnt  = 2'd1;
                n_exp_width = w_lead;
                lead_wr     = 1'b1;
            end
        end
        // string end: whatever is still pending is replaced
        if (fin) begin
            n_q         = n_q + {1'b0, n_pend_cnt};
            n_pend_cnt  = 2'd0;
            n_exp_width = 3'd0;
        end
    end

    assign n_tot    = multi ? r_exp_width : (n_q + {2'd0, has_ascii});
    assign last_idx = 2'(n_tot - 3'd1);

    // Result bytes and the budget check for each position
    always_comb begin
        seq[0] = r_pend[0];
        seq[1] = r_pend[1];
        seq[2] = r_pend[2];
        seq[3] = b;
        seq[2'(r_exp_width - 3'd1)] = b;
        n_emit = 3'd0;
        for (int j = 0; j < u8st_pkg::MaxRes; j++) begin
            if (multi) begin
                run_bytes[j] = seq[j];
            end else if (has_ascii && (2'(j) == last_idx)) begin
                run_bytes[j] = b;
            end else begin
                run_bytes[j] = u8st_pkg::ReplByte;
            end
            if (!r_stopped && (3'(j) < n_tot) &&
                ({1'b0, r_emit_cnt} + (multi ? 17'(n_tot) : 17'(j + 1)) <=
                 {1'b0, r_byte_limit})) begin
                n_emit = n_emit + 3'd1;
            end
        end
    end

    assign stop_hit = (n_tot != 3'd0) &&
                      (({1'b0, r_emit_cnt} + 17'(n_tot)) > {1'b0, r_byte_limit});

    always_comb begin
        if (fin) begin
            n_stopped  = 1'b0;
            n_emit_cnt = 16'd0;
        end else begin
            n_stopped  = r_stopped || stop_hit;
            n_emit_cnt = r_emit_cnt + 16'(n_emit);
        end
    end

    // Run record toward the queue
    assign o_push        = accept && ((n_emit != 3'd0) || fin);
    assign o_run.bytes   = run_bytes;
    assign o_run.n_res   = (n_emit == 3'd0) ? 3'd1 : n_emit;
    assign o_run.bare    = (n_emit == 3'd0);
    assign o_run.str_end = fin;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped    <= 1'b0;
            r_emit_cnt   <= 16'd0;
            r_pend_cnt   <= 2'd0;
            r_exp_width  <= 3'd0;
            r_byte_limit <= u8st_pkg::LimitReset;
        end else begin
            if (i_cfg_wr_en) begin
                r_byte_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_stopped   <= n_stopped;
                r_emit_cnt  <= n_emit_cnt;
                r_pend_cnt  <= n_pend_cnt;
                r_exp_width <= n_exp_width;
            end
        end
    end

    // Pending sequence bytes
    always_ff @(posedge i_clk) begin
        if (accept && lead_wr) begin
            r_pend[0] <= b;
        end
        if (accept && app_wr) begin
            r_pend[r_pend_cnt] <= b;
        end
    end

`ifndef SYNTHESIS
    a_pend_below_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt != 2'd0) |-> (r_exp_width > {1'b0, r_pend_cnt}))
        else $error("pending count not below sequence width");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && fin) |=> (r_pend_cnt == 2'd0 && r_emit_cnt == 16'd0 && !r_stopped))
        else $error("string state not cleared after final byte");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_stopped) |-> !(o_push && !o_run.bare))
        else $error("byte emitted after output stopped");

    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && fin) |-> o_push)
        else $error("final byte produced no run");
`endif

endmodule

/* rtl/u8st_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_queue
// Short FIFO of result runs between the input side and the output side.
// ----------------------------------------------------------------------------
module u8st_queue #(
    parameter int Depth = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8st_pkg::t_run   i_run,
    output logic             o_ready,
    output logic             o_valid,
    output u8st_pkg::t_run   o_head,
    input  logic             i_pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
    localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
    localparam logic [CntW-1:0] CntOne  = CntW'(1);

    u8st_pkg::t_run  r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_ready = (r_count != FullCnt);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrOne;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrOne;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CntOne;
                2'b01:   r_count <= r_count - CntOne;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

endmodule

/* rtl/u8st_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_back
// Walks the head run of the queue and sends its results one per transfer.
// ----------------------------------------------------------------------------
module u8st_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  u8st_pkg::t_run   i_head,
    output logic             o_pop,
    u8st_out_if.source       o_out
);

    logic [1:0] r_idx;
    logic       last;
    logic       xfer;

    assign last = (({1'b0, r_idx}) + 3'd1) == i_head.n_res;
    assign xfer = i_valid && o_out.ready;
    assign o_pop = xfer && last;

    // Output fields of the current result
    assign o_out.valid        = i_valid;
    assign o_out.out_byte     = i_head.bare ? 8'h00 : i_head.bytes[r_idx];
    assign o_out.byte_present = !i_head.bare;
    assign o_out.run_last     = last;
    assign o_out.string_end   = i_head.str_end && last;

    // Position inside the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (xfer) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

/* rtl/utf8_sanitize_truncate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate
// Streaming UTF-8 sanitizer: passes well-formed characters, replaces broken
// bytes with '?', and cuts the string off at a programmable byte limit.
//
//   channel | dir | handshake          | payload
//   i_in    | in  | valid/ready        | in_byte[7:0], is_final
//   o_out   | out | valid/ready        | out_byte[7:0], byte_present,
//           |     |                    | string_end, run_last
//   cfg     | in  | i_cfg_wr_en        | i_cfg_wr_data[15:0] (byte_limit)
//
// An input byte is taken every cycle while the run queue has room; its run
// of 0 to 4 results leaves one result per cycle while o_out.ready is high.
// The run is written into the queue when the byte is accepted, and its first
// result is sent from the queue head once the runs queued before it are out.
// Synchronous active-low reset clears the pending sequence, the budget and
// the queue; byte_limit returns to 1024.
// Output stalls back up through the queue to i_in.ready only once it is full.
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate #(
    parameter int QueueDepth = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8st_in_if.sink     i_in,
    u8st_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic           push;
    logic           pop;
    logic           q_ready;
    logic           q_valid;
    u8st_pkg::t_run run_in;
    u8st_pkg::t_run run_head;

    // Byte classification and budget
    u8st_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_run         (run_in)
    );

    // Run queue
    u8st_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (run_head),
        .i_pop   (pop)
    );

    // Result serializer
    u8st_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (run_head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* test/utf8_sanitize_truncate_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate_test
// Self-checking bench for the streaming UTF-8 sanitizer. A scoreboard class
// mirrors the decoder state and the output budget, builds the result bytes
// each accepted input byte should cause, and compares every result transfer
// in order. Directed strings cover the encoding edges. Random strings run
// under several byte limits and with idle and stall patterns on both
// channels.
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate_test;

    localparam int          CycleLimit   = 200000;
    localparam int          SettleCycles = 6;
    localparam int          BlockItems   = 12;
    localparam int          DirectedLen  = 26;
    localparam int          DirectedCut  = 23;

    // Byte classes
    localparam u8st_pkg::t_byte ContMask = 8'hC0;
    localparam u8st_pkg::t_byte ContTag  = 8'h80;
    localparam u8st_pkg::t_byte AsciiMax = 8'h7F;
    localparam u8st_pkg::t_byte Lead2Lo  = 8'hC2;
    localparam u8st_pkg::t_byte Lead2Hi  = 8'hDF;
    localparam u8st_pkg::t_byte Lead3Lo  = 8'hE0;
    localparam u8st_pkg::t_byte Lead3Hi  = 8'hEF;
    localparam u8st_pkg::t_byte Lead4Lo  = 8'hF0;
    localparam u8st_pkg::t_byte Lead4Hi  = 8'hF4;
    localparam u8st_pkg::t_byte ContLo   = 8'h80;
    localparam u8st_pkg::t_byte ContHi   = 8'hBF;

    // Code point bounds
    localparam int unsigned MinCp2       = 32'h80;
    localparam int unsigned MinCp3       = 32'h800;
    localparam int unsigned MinCp4       = 32'h10000;
    localparam int unsigned SurrLo       = 32'hD800;
    localparam int unsigned SurrHi       = 32'hDFFF;
    localparam int unsigned MaxCp        = 32'h10FFFF;

    // Byte limit for each random block
    localparam logic [15:0] LimitPlan [9] = '{16'hFFFF, 16'd0, 16'd5, 16'd1, 16'd2,
                                              16'd9, 16'd0, 16'd3, 16'd12};

    // Directed strings: bit 8 marks the last byte of a string
    localparam logic [8:0] Directed [DirectedLen] = '{
        // ASCII extremes and the highest 2-byte character
        9'h000, 9'h0DF, 9'h0BF, 9'h17F,
        // smallest 3-byte character, then a surrogate
        9'h0E0, 9'h0A0, 9'h080, 9'h0ED, 9'h0A0, 9'h180,
        // highest code point, then an overlong 3-byte form
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0E0, 9'h080, 9'h180,
        // overlong lead, lone continuation, broken sequence, cut by string end
        9'h0C0, 9'h080, 9'h0C3, 9'h041, 9'h0E2, 9'h182,
        // run into a limit of two: the string closes with a bare end marker
        9'h0C2, 9'h080, 9'h141
    };

    typedef struct packed {
        u8st_pkg::t_byte data;
        logic            present;
        logic            str_end;
        logic            last;
    } t_out_item;

    // ------------------------------------------------------------------------
    // Scoreboard: decoder state, budget and the queue of expected results
    // ------------------------------------------------------------------------
    class u8_sanitize_scoreboard;
        logic [15:0]     limit;
        u8st_pkg::t_byte held [3];
        int unsigned     held_n;
        int unsigned     seq_width;
        int unsigned     out_count;
        bit              cut_off;
        u8st_pkg::t_byte run_bytes [$];
        t_out_item       expected_q [$];
        int              failures;
        int              results_seen;

        function new();
            limit        = u8st_pkg::LimitReset;
            held_n       = 0;
            seq_width    = 0;
            out_count    = 0;
            cut_off      = 1'b0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            limit = value;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        // One '?' needs one free byte of budget
        function void put_repl();
            if (cut_off)
                return;
            if (out_count + 1 > limit) begin
                cut_off = 1'b1;
                return;
            end
            run_bytes = {run_bytes, u8st_pkg::ReplByte};
            out_count++;
        endfunction

        // A character goes out whole or not at all
        function void put_char(u8st_pkg::t_byte seq [4], int unsigned width);
            if (cut_off)
                return;
            if (out_count + width > limit) begin
                cut_off = 1'b1;
                return;
            end
            for (int i = 0; i < width; i++)
                run_bytes = {run_bytes, seq[i]};
            out_count += width;
        endfunction

        function void flush_held();
            for (int i = 0; i < held_n; i++)
                put_repl();
            held_n    = 0;
            seq_width = 0;
        endfunction

        function void take_lead(u8st_pkg::t_byte b);
            u8st_pkg::t_byte seq [4];
            seq_width = 0;
            if (b <= AsciiMax) begin
                seq = '{b, 8'h00, 8'h00, 8'h00};
                put_char(seq, 1);
                return;
            end
            if (b >= Lead2Lo && b <= Lead2Hi)
                seq_width = 2;
            else if (b >= Lead3Lo && b <= Lead3Hi)
                seq_width = 3;
            else if (b >= Lead4Lo && b <= Lead4Hi)
                seq_width = 4;
            if (seq_width == 0) begin
                put_repl();
                return;
            end
            held[0] = b;
            held_n  = 1;
        endfunction

        function void note_input(u8st_pkg::t_byte b, logic fin);
            u8st_pkg::t_byte seq [4];
            int unsigned     width;
            int unsigned     cp;
            bit              ok;
            t_out_item       item;
            run_bytes.delete();

            if (held_n != 0 && (b & ContMask) == ContTag) begin
                if (held_n + 1 == seq_width) begin
                    // sequence complete: decode and range check
                    width = seq_width;
                    seq   = '{8'h00, 8'h00, 8'h00, 8'h00};
                    for (int i = 0; i < held_n; i++)
                        seq[i] = held[i];
                    seq[width-1] = b;
                    case (width)
                        2:       cp = seq[0] & 8'h1F;
                        3:       cp = seq[0] & 8'h0F;
                        default: cp = seq[0] & 8'h07;
                    endcase
                    for (int i = 1; i < width; i++)
                        cp = (cp << 6) | (seq[i] & 8'h3F);
                    ok = (width == 2 && cp >= MinCp2) || (width == 3 && cp >= MinCp3) ||
                         (width == 4 && cp >= MinCp4);
                    ok = ok && !(cp >= SurrLo && cp <= SurrHi) && cp <= MaxCp;
                    held_n    = 0;
                    seq_width = 0;
                    if (ok)
                        put_char(seq, width);
                    else
                        repeat (width) put_repl();
                end else begin
                    held[held_n] = b;
                    held_n++;
                end
            end else begin
                // broken sequence or plain lead
                flush_held();
                take_lead(b);
            end

            if (fin)
                flush_held();

            if (fin && run_bytes.size() == 0) begin
                item = '{data: 8'h00, present: 1'b0, str_end: 1'b1, last: 1'b1};
                expected_q = {expected_q, item};
            end else begin
                for (int k = 0; k < run_bytes.size(); k++) begin
                    item = '{data: run_bytes[k], present: 1'b1,
                             str_end: fin && (k == run_bytes.size() - 1),
                             last: (k == run_bytes.size() - 1)};
                    expected_q = {expected_q, item};
                end
            end

            if (fin) begin
                out_count = 0;
                cut_off   = 1'b0;
            end
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_q.size() == 0) begin
                log_failure($sformatf(
                    "result %0d with nothing expected: byte %02h present %0b end %0b last %0b",
                    results_seen, got.data, got.present, got.str_end, got.last));
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.data !== want.data || got.present !== want.present ||
                got.str_end !== want.str_end || got.last !== want.last)
                log_failure({
                    $sformatf("result %0d: expected byte %02h present %0b end %0b last %0b, ",
                              results_seen, want.data, want.present, want.str_end,
                              want.last),
                    $sformatf("got byte %02h present %0b end %0b last %0b",
                              got.data, got.present, got.str_end, got.last)});
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    u8st_in_if  in_ch ();
    u8st_out_if out_ch ();

    u8_sanitize_scoreboard sb;

    int src_idle;
    int snk_idle;
    bit paused;

    utf8_sanitize_truncate u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin : run_watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Result side: check each transfer, then pick ready for the next edge
    initial begin : result_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result('{data: out_ch.out_byte, present: out_ch.byte_present,
                                  str_end: out_ch.string_end, last: out_ch.run_last});
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // One input transfer; returns at the edge where it is taken
    task automatic send_byte(input u8st_pkg::t_byte b, input logic fin);
        while ($urandom_range(0, 99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.is_final <= fin;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_input(b, fin);
    endtask

    // Hold the input off until every expected result has left the block
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // Random string: mostly well-formed characters with random content,
    // plus cut-short sequences and raw noise bytes
    task automatic play_random_string(inout int sent);
        u8st_pkg::t_byte s [$];
        int              n_chars;
        int              pick;
        int              width;
        int              n_cont;
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                s = {s, u8st_pkg::t_byte'($urandom_range(0, AsciiMax))};
            end else if (pick < 93) begin
                if (pick < 55)
                    width = 2;
                else if (pick < 72)
                    width = 3;
                else if (pick < 85)
                    width = 4;
                else
                    width = $urandom_range(2, 4);
                n_cont = (pick < 85) ? width - 1 : $urandom_range(0, width - 2);
                case (width)
                    2:       s = {s, u8st_pkg::t_byte'($urandom_range(Lead2Lo, Lead2Hi))};
                    3:       s = {s, u8st_pkg::t_byte'($urandom_range(Lead3Lo, Lead3Hi))};
                    default: s = {s, u8st_pkg::t_byte'($urandom_range(Lead4Lo, Lead4Hi))};
                endcase
                repeat (n_cont) s = {s, u8st_pkg::t_byte'($urandom_range(ContLo, ContHi))};
            end else begin
                s = {s, u8st_pkg::t_byte'($urandom_range(0, 255))};
            end
        end
        for (int i = 0; i < s.size(); i++) begin
            send_byte(s[i], i == s.size() - 1);
            sent++;
            // drain the block mid-string now and then
            if (i != s.size() - 1 && (!paused || $urandom_range(0, 24) == 0)) begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          sent;
        logic [15:0] lim;
        sb       = new();
        src_idle = 36;
        snk_idle = 87;
        paused   = 1'b0;

        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= '0;
        in_ch.is_final <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings, first at the reset limit
        for (int i = 0; i < DirectedLen; i++) begin
            if (i == DirectedCut) begin
                settle();
                write_limit(16'd2);
            end
            send_byte(Directed[i][7:0], Directed[i][8]);
        end

        // random strings: three blocks per idle pattern
        for (int blk = 0; blk < 9; blk++) begin
            src_idle = (blk < 3) ? 36 : (blk < 6) ? 87 : 0;
            snk_idle = (blk < 3) ? 87 : (blk < 6) ? 36 : 0;
            lim      = LimitPlan[blk];
            if (blk == 6)
                lim = 16'($urandom_range(0, 16'hFFFF));
            settle();
            write_limit(lim);
            sent = 0;
            while (sent < BlockItems)
                play_random_string(sent);
        end

        settle();
        if (sb.failures == 0 && sb.waiting() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/u8st_pkg.sv
rtl/u8st_in_if.sv
rtl/u8st_out_if.sv
rtl/u8st_front.sv
rtl/u8st_queue.sv
rtl/u8st_back.sv
rtl/utf8_sanitize_truncate.sv
test/utf8_sanitize_truncate_test.sv
